[design/pec_pkg.sv]
package pec_pkg;

    // percent sign, the escape marker
    localparam logic [15:0] PERCENT = 16'h0025;

    // number of hex digits in one escape
    localparam int unsigned ESC_DIGITS = 4;

    // depth of the command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic REG_DIRECTION = 1'b0;

    // direction codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // safe set below 0x80, bit n set means unit n passes unchanged
    localparam logic [127:0] SAFE_SET =
        128'h6FFFFFFE_2FFFFFFE_23FF4001_00000000;

    // one command for the back end
    typedef struct packed {
        logic        escape;   // 1: emit '%' and four hex digits
        logic [15:0] value;
    } cmd_t;

    function automatic logic is_safe(input logic [15:0] u);
        logic r;
        r = 1'b0;
        if (u[15:7] == 9'd0)
        begin
            r = SAFE_SET[u[6:0]];
        end
        return r;
    endfunction

    // lowercase ascii hex digit of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10)
        begin
            r = 8'h30 + {4'd0, nib};
        end
        else
        begin
            r = 8'h61 + {4'd0, nib} - 8'd10;
        end
        return r;
    endfunction

    // hex value of a unit, bit 4 set when the unit is no hex digit
    function automatic logic [4:0] hex_value(input logic [15:0] u);
        logic [4:0] r;
        r = 5'h10;
        if (u >= 16'h0030 && u <= 16'h0039)
        begin
            r = {1'b0, 4'(u - 16'h0030)};
        end
        else if (u >= 16'h0061 && u <= 16'h0066)
        begin
            r = {1'b0, 4'(u - 16'h0061 + 16'd10)};
        end
        else if (u >= 16'h0041 && u <= 16'h0046)
        begin
            r = {1'b0, 4'(u - 16'h0041 + 16'd10)};
        end
        return r;
    endfunction

endpackage

[design/pec_front.sv]
module pec_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              direction,
    input  logic              esc_clear,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [15:0]       in_unit,
    input  logic              q_full,
    output logic              q_push,
    output pec_pkg::cmd_t     q_cmd
);
    import pec_pkg::*;

    logic [2:0]  digits_reg, digits_next;
    logic [15:0] value_reg, value_next;
    logic        bad_reg, bad_next;

    logic        accept;
    logic [4:0]  dval;
    logic        bad_acc;
    logic [15:0] value_acc;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // digit collection for the open escape
    assign dval      = hex_value(in_unit);
    assign bad_acc   = bad_reg | dval[4];
    assign value_acc = dval[4] ? value_reg : {value_reg[11:0], dval[3:0]};

    // classify the accepted word
    always_comb
    begin
        digits_next   = digits_reg;
        value_next    = value_reg;
        bad_next      = bad_reg;
        q_push        = 1'b0;
        q_cmd.escape  = 1'b0;
        q_cmd.value   = in_unit;
        if (esc_clear)
        begin
            digits_next = 3'd0;
            value_next  = 16'd0;
            bad_next    = 1'b0;
        end
        else if (accept)
        begin
            if (direction == DIR_ENCODE)
            begin
                q_push       = 1'b1;
                q_cmd.escape = !is_safe(in_unit);
            end
            else if (digits_reg == 3'd0)
            begin
                if (in_unit == PERCENT)
                begin
                    digits_next = 3'd1;
                    value_next  = 16'd0;
                    bad_next    = 1'b0;
                end
                else
                begin
                    q_push = 1'b1;
                end
            end
            else if (digits_reg == 3'(ESC_DIGITS))
            begin
                q_push      = 1'b1;
                q_cmd.value = bad_acc ? 16'd0 : value_acc;
                digits_next = 3'd0;
                value_next  = 16'd0;
                bad_next    = 1'b0;
            end
            else
            begin
                digits_next = digits_reg + 3'd1;
                value_next  = value_acc;
                bad_next    = bad_acc;
            end
        end
    end

    // escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits_reg <= 3'd0;
            value_reg  <= 16'd0;
            bad_reg    <= 1'b0;
        end
        else
        begin
            digits_reg <= digits_next;
            value_reg  <= value_next;
            bad_reg    <= bad_next;
        end
    end

endmodule

[design/pec_queue.sv]
module pec_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pec_pkg::cmd_t     push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output pec_pkg::cmd_t     head
);
    import pec_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[design/pec_back.sv]
module pec_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  pec_pkg::cmd_t     q_head,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [15:0]       out_unit,
    output logic              out_last
);
    import pec_pkg::*;

    cmd_t       cmd_reg, cmd_next;
    logic [2:0] step_reg, step_next;
    logic       busy_reg, busy_next;
    logic [3:0] nib;

    assign out_valid = busy_reg;

    // current word from the command and step
    always_comb
    begin
        unique case (step_reg)
            3'd1:    nib = cmd_reg.value[15:12];
            3'd2:    nib = cmd_reg.value[11:8];
            3'd3:    nib = cmd_reg.value[7:4];
            default: nib = cmd_reg.value[3:0];
        endcase
        if (!cmd_reg.escape)
        begin
            out_unit = cmd_reg.value;
            out_last = 1'b1;
        end
        else if (step_reg == 3'd0)
        begin
            out_unit = PERCENT;
            out_last = 1'b0;
        end
        else
        begin
            out_unit = {8'd0, hex_char(nib)};
            out_last = (step_reg == 3'(ESC_DIGITS));
        end
    end

    // step through the command, load the next one when done
    always_comb
    begin
        cmd_next  = cmd_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        q_pop     = 1'b0;
        if (!busy_reg || (out_ready && out_last))
        begin
            q_pop     = !q_empty;
            busy_next = !q_empty;
            cmd_next  = q_head;
            step_next = 3'd0;
        end
        else if (out_ready)
        begin
            step_next = step_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

[design/percent_escape_codec16.sv]
// channel   direction  contents
// s_axis    in         tdata[15:0] code_unit
// m_axis    out        tdata[15:0] out_unit, tlast = last
// apb       in/out     register 0 at 0x0: direction (0 encode, 1 decode)
//
// a safe or decoded word is queued and then registered in the back end, leaving
// one word a cycle while m_axis_tready is high; an escaped word yields five output
// words, which the output stage steps through digit by digit before its next word
// a two-entry command queue lets input keep flowing while output is stalled, until both entries are full
// rst_n clears direction, the open escape and all queued words
module percent_escape_codec16 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] out_unit
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pec_pkg::*;

    logic direction_reg;
    logic cfg_write;
    logic dir_write;
    logic q_push, q_pop, q_full, q_empty;
    cmd_t q_cmd, q_head;

    // register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign dir_write = cfg_write && (paddr[2] == REG_DIRECTION);
    assign prdata    = (paddr[2] == REG_DIRECTION) ? {31'd0, direction_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_ENCODE;
        end
        else if (dir_write)
        begin
            direction_reg <= pwdata[0];
        end
    end

    pec_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .direction (direction_reg),
        .esc_clear (dir_write),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_unit   (s_axis_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    pec_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    pec_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_unit  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
